[rtl/log_record_stream_decoder_core_defines.svh]
// Assertion helpers used by the checker file.
`ifndef LOG_RECORD_STREAM_DECODER_CORE_DEFINES_SVH
`define LOG_RECORD_STREAM_DECODER_CORE_DEFINES_SVH

// Clocked check, off while reset is asserted.
`define LRSD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define LRSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/lrsd_pkg.sv]
package lrsd_pkg;

  localparam int unsigned LENGTH_BITS = 32;
  localparam logic [31:0] LEN_MASK    = 32'((64'd1 << LENGTH_BITS) - 64'd1);
  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES    = 32'hFFFFFFFF;
  localparam logic [31:0] HDR_BYTES   = 32'd21;
  localparam logic [7:0]  TYPE_DEL    = 8'd1;
  localparam logic [7:0]  TYPE_TTL    = 8'd2;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_AW     = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    PH_HDR = 2'd0,
    PH_KEY = 2'd1,
    PH_VAL = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_KEY    = 2'd0,
    KIND_VAL    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNC     = 3'd1,
    ST_CRC       = 3'd2,
    ST_BAD_TYPE  = 3'd3,
    ST_ZERO_SEQ  = 3'd4,
    ST_DEL_VALUE = 3'd5,
    ST_TTL_SHORT = 3'd6,
    ST_TTL_ZERO  = 3'd7
  } status_e;

  // One classified input byte: an optional data byte and an optional status.
  typedef struct packed {
    logic        has_byte;
    logic        byte_is_val;
    logic [7:0]  data;
    logic        has_status;
    status_e     status;
    logic [7:0]  rec_type;
    logic [63:0] seq;
    logic [31:0] key_len;
    logic [31:0] val_len;
    logic [63:0] expiry;
    logic [33:0] rec_bytes;
  } entry_t;

  // Reflected CRC-32 over one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/lrsd_front.sv]
module lrsd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      in_byte_i,
  input  logic            end_of_buffer_i,
  output logic            wr_o,
  output lrsd_pkg::entry_t entry_o
);
  import lrsd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] cnt_q, cnt_d, cnt_inc;
  logic [31:0] scrc_q, scrc_d;
  logic [31:0] crc_q, crc_d;
  logic [7:0]  type_q, type_d;
  logic [63:0] seq_q, seq_d;
  logic [31:0] ksz_q, ksz_d;
  logic [31:0] vsz_q, vsz_d;
  logic [63:0] exp_q, exp_d;
  logic [33:0] pos_q, pos_d;
  logic        hold_q, hold_d;
  logic        done, has_byte, byte_is_val, emit_st, ttl;
  status_e     st;
  logic [31:0] cnt_m5, cnt_m13, cnt_m17;

  assign cnt_inc = cnt_q + 32'd1;
  assign cnt_m5  = cnt_q - 32'd5;
  assign cnt_m13 = cnt_q - 32'd13;
  assign cnt_m17 = cnt_q - 32'd17;

  // Parse one byte and classify its results
  always_comb begin
    phase_d = phase_q; cnt_d = cnt_q; scrc_d = scrc_q; crc_d = crc_q;
    type_d = type_q; seq_d = seq_q; ksz_d = ksz_q; vsz_d = vsz_q;
    exp_d = exp_q; pos_d = pos_q + 34'd1; hold_d = hold_q;
    done = 1'b0; has_byte = 1'b0; byte_is_val = 1'b0;
    case (phase_q)
      PH_HDR: begin
        if (cnt_q < 32'd4) begin
          scrc_d[8*cnt_q[1:0] +: 8] = in_byte_i;
        end else begin
          crc_d = crc_byte(crc_q, in_byte_i);
          if (cnt_q == 32'd4) type_d = in_byte_i;
          else if (cnt_q < 32'd13) seq_d[8*cnt_m5[2:0] +: 8] = in_byte_i;
          else if (cnt_q < 32'd17) ksz_d[8*cnt_m13[1:0] +: 8] = in_byte_i;
          else vsz_d[8*cnt_m17[1:0] +: 8] = in_byte_i;
        end
        cnt_d = cnt_inc;
        if (cnt_inc >= HDR_BYTES) begin
          ksz_d = ksz_d & LEN_MASK;
          vsz_d = vsz_d & LEN_MASK;
          cnt_d = '0;
          if (ksz_d != 32'd0) phase_d = PH_KEY;
          else if (vsz_d != 32'd0) phase_d = PH_VAL;
          else done = 1'b1;
        end
      end
      PH_KEY: begin
        crc_d = crc_byte(crc_q, in_byte_i);
        has_byte = 1'b1;
        cnt_d = cnt_inc;
        if (cnt_inc >= ksz_q) begin
          cnt_d = '0;
          if (vsz_q != 32'd0) phase_d = PH_VAL;
          else done = 1'b1;
        end
      end
      default: begin
        crc_d = crc_byte(crc_q, in_byte_i);
        if (type_q == TYPE_TTL && cnt_q < 32'd8) begin
          exp_d[8*cnt_q[2:0] +: 8] = in_byte_i;
        end else begin
          has_byte = 1'b1;
          byte_is_val = 1'b1;
        end
        cnt_d = cnt_inc;
        if (cnt_inc >= vsz_q) done = 1'b1;
      end
    endcase

    // Pick the record status in priority order
    ttl = (type_d == TYPE_TTL);
    if (!done) st = ST_TRUNC;
    else if ((crc_d ^ CRC_ONES) != scrc_d) st = ST_CRC;
    else if (type_d > TYPE_TTL) st = ST_BAD_TYPE;
    else if (seq_d == 64'd0) st = ST_ZERO_SEQ;
    else if (type_d == TYPE_DEL && vsz_d != 32'd0) st = ST_DEL_VALUE;
    else if (ttl && vsz_d < 32'd8) st = ST_TTL_SHORT;
    else if (ttl && exp_d == 64'd0) st = ST_TTL_ZERO;
    else st = ST_OK;
    emit_st = done | end_of_buffer_i;

    entry_o.has_byte    = has_byte;
    entry_o.byte_is_val = byte_is_val;
    entry_o.data        = in_byte_i;
    entry_o.has_status  = emit_st;
    entry_o.status      = st;
    entry_o.rec_type    = type_d;
    entry_o.seq         = seq_d;
    entry_o.key_len     = ksz_d;
    entry_o.val_len     = ttl ? ((vsz_d >= 32'd8) ? vsz_d - 32'd8 : 32'd0) : vsz_d;
    entry_o.expiry      = (st != ST_TRUNC && ttl && vsz_d >= 32'd8) ? exp_d : 64'd0;
    entry_o.rec_bytes   = pos_d;

    // Start a new record after a status; drop bytes after an error
    if (emit_st) begin
      if (st != ST_OK && !end_of_buffer_i) hold_d = 1'b1;
      phase_d = PH_HDR; cnt_d = '0; scrc_d = '0; crc_d = CRC_ONES;
      type_d = '0; seq_d = '0; ksz_d = '0; vsz_d = '0; exp_d = '0; pos_d = '0;
    end
    if (hold_q) begin
      phase_d = phase_q; cnt_d = cnt_q; scrc_d = scrc_q; crc_d = crc_q;
      type_d = type_q; seq_d = seq_q; ksz_d = ksz_q; vsz_d = vsz_q;
      exp_d = exp_q; pos_d = pos_q;
      hold_d = !end_of_buffer_i;
    end
  end

  assign wr_o = accept_i & ~hold_q & (has_byte | emit_st);

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR; cnt_q <= '0; scrc_q <= '0; crc_q <= CRC_ONES;
      type_q <= '0; seq_q <= '0; ksz_q <= '0; vsz_q <= '0; exp_q <= '0;
      pos_q <= '0; hold_q <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d; cnt_q <= cnt_d; scrc_q <= scrc_d; crc_q <= crc_d;
      type_q <= type_d; seq_q <= seq_d; ksz_q <= ksz_d; vsz_q <= vsz_d;
      exp_q <= exp_d; pos_q <= pos_d; hold_q <= hold_d;
    end
  end

endmodule

[rtl/lrsd_fifo.sv]
module lrsd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  lrsd_pkg::entry_t wdata_i,
  input  logic             rd_i,
  output lrsd_pkg::entry_t rdata_o,
  output logic             full_o,
  output logic             empty_o
);
  import lrsd_pkg::*;

  entry_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wp_q, rp_q;
  logic [FIFO_AW:0]     cnt_q;

  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  // Store words
  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + FIFO_AW'(1);
      if (rd_i) rp_q <= rp_q + FIFO_AW'(1);
      cnt_q <= cnt_q + {{FIFO_AW{1'b0}}, wr_i} - {{FIFO_AW{1'b0}}, rd_i};
    end
  end

endmodule

[rtl/lrsd_back.sv]
module lrsd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lrsd_pkg::entry_t entry_i,
  input  logic             q_empty_i,
  output logic             q_rd_o,
  input  logic             pop,
  output logic             empty,
  output logic [1:0]       kind_o,
  output logic [7:0]       out_byte_o,
  output logic [7:0]       rec_type_o,
  output logic [63:0]      sequence_res_o,
  output logic [31:0]      key_length_o,
  output logic [31:0]      value_length_o,
  output logic [63:0]      expiry_ms_o,
  output logic [33:0]      record_bytes_o,
  output logic [2:0]       status_o,
  output logic             last_o
);
  import lrsd_pkg::*;

  logic sub_q, sub_d, sel_st, fin;

  assign empty  = q_empty_i;
  assign sel_st = !entry_i.has_byte | sub_q;
  assign fin    = sel_st | !entry_i.has_status;
  assign last_o = fin;
  assign q_rd_o = pop & !q_empty_i & fin;

  // Expand a word into its byte result, its status result, or the byte and then the status
  always_comb begin
    kind_o = sel_st ? KIND_STATUS : (entry_i.byte_is_val ? KIND_VAL : KIND_KEY);
    out_byte_o     = sel_st ? 8'd0 : entry_i.data;
    rec_type_o     = sel_st ? entry_i.rec_type : 8'd0;
    sequence_res_o = sel_st ? entry_i.seq : 64'd0;
    key_length_o   = sel_st ? entry_i.key_len : 32'd0;
    value_length_o = sel_st ? entry_i.val_len : 32'd0;
    expiry_ms_o    = sel_st ? entry_i.expiry : 64'd0;
    record_bytes_o = sel_st ? entry_i.rec_bytes : 34'd0;
    status_o       = sel_st ? entry_i.status : ST_OK;
    sub_d = sub_q;
    if (pop && !q_empty_i) sub_d = !fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sub_q <= 1'b0;
    else sub_q <= sub_d;
  end

endmodule

[rtl/log_record_stream_decoder_core.sv]
// Channel  | Handshake           | Word
// ---------+---------------------+------------------------------------------
// input    | push / full         | in_byte_i, end_of_buffer_i
// result   | empty / pop         | kind, out_byte, header fields, status, last
//
// One input byte is taken per cycle while the queue has room; the parser,
// including the byte-wide CRC step and the status checks, is combinational,
// and its word is written into the queue, from which the result ports read.
// A byte that yields a data byte and a record status gives two result words, the byte and then the status.
// A four-word queue absorbs output stalls; full rises when four words wait.
// Reset is asynchronous, active low, and empties the queue.
module log_record_stream_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_buffer_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [7:0]  rec_type_o,
  output logic [63:0] sequence_res_o,
  output logic [31:0] key_length_o,
  output logic [31:0] value_length_o,
  output logic [63:0] expiry_ms_o,
  output logic [33:0] record_bytes_o,
  output logic [2:0]  status_o,
  output logic        last_o
);
  import lrsd_pkg::*;

  entry_t wentry, rentry;
  logic   wr, rd, q_empty, accept;

  assign accept = push & ~full;

  lrsd_front u_front (
    .clk_i, .rst_ni, .accept_i(accept), .in_byte_i, .end_of_buffer_i,
    .wr_o(wr), .entry_o(wentry)
  );

  lrsd_fifo u_fifo (
    .clk_i, .rst_ni, .wr_i(wr), .wdata_i(wentry), .rd_i(rd),
    .rdata_o(rentry), .full_o(full), .empty_o(q_empty)
  );

  lrsd_back u_back (
    .clk_i, .rst_ni, .entry_i(rentry), .q_empty_i(q_empty), .q_rd_o(rd),
    .pop, .empty, .kind_o, .out_byte_o, .rec_type_o, .sequence_res_o,
    .key_length_o, .value_length_o, .expiry_ms_o, .record_bytes_o,
    .status_o, .last_o
  );

endmodule

[rtl/lrsd_checker.sv]
`include "log_record_stream_decoder_core_defines.svh"

module lrsd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  kind_o,
  input logic [33:0] record_bytes_o,
  input logic [2:0]  status_o,
  input logic        last_o
);
  import lrsd_pkg::*;

  logic st_word, byte_word, byte_clean, split_pop;

  // Classify the word on the result ports
  assign st_word    = !empty && kind_o == KIND_STATUS;
  assign byte_word  = !empty && kind_o != KIND_STATUS;
  assign byte_clean = status_o == ST_OK && record_bytes_o == '0;
  assign split_pop  = pop && !empty && !last_o;

  `LRSD_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> empty, "results during reset")
  `LRSD_ASSERT(a_st_last, clk_i, rst_ni, st_word |-> last_o, "status not last")
  `LRSD_ASSERT(a_byte_clean, clk_i, rst_ni, byte_word |-> byte_clean, "byte word carries status")
  `LRSD_ASSERT(a_kind_ok, clk_i, rst_ni, !empty |-> (kind_o <= KIND_STATUS), "bad kind")
  `LRSD_ASSERT(a_byte_then_st, clk_i, rst_ni, split_pop |=> st_word, "no status after byte")

endmodule

bind log_record_stream_decoder_core lrsd_checker u_lrsd_checker (
  .clk_i, .rst_ni, .empty, .pop, .kind_o, .record_bytes_o, .status_o, .last_o
);
